// ----- hdl/i2cme_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
package i2cme_pkg;

	// Command codes carried in the operation field
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;
	localparam logic [15:0] HALF_PERIOD_RST = 16'd250;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] tx_byte;
		logic       send_nack;
		logic       sda_level;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} rsp_t;

endpackage

// ----- hdl/i2cme_if.sv -----
// Valid/ready channel interfaces for command words, result words and configuration.
interface i2cme_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] tx_byte;
	logic       send_nack;
	logic       sda_level;

	modport source (output valid, operation, tx_byte, send_nack, sda_level, input ready);
	modport sink (input valid, operation, tx_byte, send_nack, sda_level, output ready);
endinterface

interface i2cme_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
		ack_seen, input ready);
	modport sink (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
		ack_seen, output ready);
endinterface

interface i2cme_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] half_period;

	modport source (output valid, half_period, input ready);
	modport sink (input valid, half_period, output ready);
endinterface

// ----- hdl/i2cme_engine.sv -----
// Pin sequencer: advances the bus state by one tick per command word.
module i2cme_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  i2cme_pkg::cmd_t     cmd,
	input  logic [15:0]         half_period,
	output i2cme_pkg::rsp_t     rsp
);
	import i2cme_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B,
		PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_RD_HIGH
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_cnt_q, bit_cnt_d;
	logic [15:0] tick_cnt_q, tick_cnt_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  rx_q, rx_d;
	logic        ack_q, ack_d;
	logic        nack_q, nack_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        done;
	logic [3:0]  bit_inc;
	logic [7:0]  shift_in;
	logic        half_end;

	assign bit_inc  = bit_cnt_q + 4'd1;
	assign shift_in = {shift_q[6:0], cmd.sda_level};
	assign half_end = ({1'b0, tick_cnt_q} + 17'd1) >= {1'b0, half_period};

	// Next state for this tick
	always_comb begin
		phase_d    = phase_q;
		bit_cnt_d  = bit_cnt_q;
		tick_cnt_d = tick_cnt_q;
		shift_d    = shift_q;
		rx_d       = rx_q;
		ack_d      = ack_q;
		nack_d     = nack_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		done       = 1'b0;
		if (tick) begin
			if (phase_q == PH_IDLE) begin
				// Launch a new command; unknown codes do nothing
				unique case (cmd.operation)
					OP_START: begin
						tick_cnt_d = '0; bit_cnt_d = '0;
						scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_START_A;
					end
					OP_STOP: begin
						tick_cnt_d = '0; bit_cnt_d = '0;
						scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_STOP_A;
					end
					OP_WRITE: begin
						tick_cnt_d = '0; bit_cnt_d = '0;
						scl_d   = 1'b0;
						sda_d   = cmd.tx_byte[7];
						shift_d = {cmd.tx_byte[6:0], 1'b0};
						phase_d = PH_WR_LOW;
					end
					OP_READ: begin
						tick_cnt_d = '0; bit_cnt_d = '0;
						scl_d   = 1'b0; sda_d = 1'b1;
						shift_d = '0;
						nack_d  = cmd.send_nack;
						phase_d = PH_RD_LOW;
					end
					default: ;
				endcase
			end else if (half_end) begin
				// Half period over: take the pin action
				tick_cnt_d = '0;
				unique case (phase_q)
					PH_START_A: begin sda_d = 1'b0; phase_d = PH_START_B; end
					PH_START_B: begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
					PH_STOP_A:  begin scl_d = 1'b1; phase_d = PH_STOP_B; end
					PH_STOP_B:  begin sda_d = 1'b1; phase_d = PH_IDLE; done = 1'b1; end
					PH_WR_LOW:  begin scl_d = 1'b1; phase_d = PH_WR_HIGH; end
					PH_WR_HIGH: begin
						scl_d = 1'b0;
						if (bit_cnt_q >= BITS_PER_BYTE) begin
							ack_d   = cmd.sda_level;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_cnt_d = bit_inc;
							if (bit_inc < BITS_PER_BYTE) begin
								sda_d   = shift_q[7];
								shift_d = {shift_q[6:0], 1'b0};
							end else begin
								sda_d = 1'b1;
							end
							phase_d = PH_WR_LOW;
						end
					end
					PH_RD_LOW:  begin scl_d = 1'b1; phase_d = PH_RD_HIGH; end
					PH_RD_HIGH: begin
						scl_d = 1'b0;
						if (bit_cnt_q >= BITS_PER_BYTE) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							shift_d   = shift_in;
							bit_cnt_d = bit_inc;
							if (bit_inc >= BITS_PER_BYTE) begin
								rx_d  = shift_in;
								sda_d = nack_q;
							end
							phase_d = PH_RD_LOW;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end else begin
				tick_cnt_d = tick_cnt_q + 16'd1;
			end
		end
	end

	// Result of this tick, seen after the update
	always_comb begin
		rsp.scl_level   = scl_d;
		rsp.sda_release = sda_d;
		rsp.busy_res    = (phase_d != PH_IDLE);
		rsp.done_res    = done;
		rsp.rx_byte     = rx_d;
		rsp.ack_seen    = ack_d;
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_cnt_q  <= '0;
			tick_cnt_q <= '0;
			shift_q    <= '0;
			rx_q       <= '0;
			ack_q      <= 1'b0;
			nack_q     <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
		end else begin
			phase_q    <= phase_d;
			bit_cnt_q  <= bit_cnt_d;
			tick_cnt_q <= tick_cnt_d;
			shift_q    <= shift_d;
			rx_q       <= rx_d;
			ack_q      <= ack_d;
			nack_q     <= nack_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
		end
	end

endmodule

// ----- hdl/i2cme_rsp_buf.sv -----
// Two-entry result buffer: output register plus skid entry.
module i2cme_rsp_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cme_pkg::rsp_t push_data,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output i2cme_pkg::rsp_t out_data
);
	import i2cme_pkg::*;

	rsp_t       head_q;
	rsp_t       skid_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;
	assign room      = (cnt_q != 2'd2);

	// Track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Move words between head and skid
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				head_q <= push_data;
			end else begin
				head_q <= skid_q;
			end
			if (push && cnt_q == 2'd2) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

// ----- hdl/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine.
// Each command word is one tick of the bus timing and yields exactly one result word
// with the pin levels, busy and done flags, the last received byte and the last ack
// sample. One word is taken every clock cycle unless a full result buffer blocks the
// input register. A word passes through the input register, the pin sequencer and a
// two-entry result buffer, and its result is offered on the result channel once it is
// written into the buffer. The buffer lets the input keep flowing for one extra word
// while a result waits; the input register holds when the buffer is full.
// SCL and SDA change once every half_period ticks (reset 250, zero acts as one).
// Commands that arrive while busy and codes above 4 are ignored.
module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	i2cme_cmd_if.sink   cmd,
	i2cme_rsp_if.source rsp,
	i2cme_cfg_if.sink   cfg
);
	import i2cme_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        room;
	logic        s1_fire;
	logic [15:0] half_period_q;
	rsp_t        rsp_d;
	rsp_t        rsp_out;

	assign s1_fire   = valid_s1 && room;
	assign cmd.ready = !valid_s1 || room;
	assign cfg.ready = 1'b1;

	// Hold the half period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (cfg.valid) begin
			half_period_q <= cfg.half_period;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= '{operation: cmd.operation, tx_byte: cmd.tx_byte,
				send_nack: cmd.send_nack, sda_level: cmd.sda_level};
		end
	end

	i2cme_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (s1_fire),
		.cmd         (cmd_s1),
		.half_period (half_period_q),
		.rsp         (rsp_d)
	);

	i2cme_rsp_buf u_rsp_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_fire),
		.push_data (rsp_d),
		.room      (room),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp_out)
	);

	// Drive result word onto the channel
	assign rsp.scl_level   = rsp_out.scl_level;
	assign rsp.sda_release = rsp_out.sda_release;
	assign rsp.busy_res    = rsp_out.busy_res;
	assign rsp.done_res    = rsp_out.done_res;
	assign rsp.rx_byte     = rsp_out.rx_byte;
	assign rsp.ack_seen    = rsp_out.ack_seen;

	// A completing tick leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && rsp_d.done_res |-> !rsp_d.busy_res)
		else $error("done reported while still busy");

	// Every command ends with SCL low or SDA released
	a_done_pins: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && rsp_d.done_res |-> !rsp_d.scl_level || rsp_d.sda_release)
		else $error("command finished with bad pin levels");

	// A blocked input word stays in place
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(cmd_s1))
		else $error("input word lost while result buffer full");

endmodule
